// ===== rtl/dsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared types, codes and helpers for the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

   // Bitmap word geometry
   localparam int WORD_BITS  = 32;
   localparam int WORD_BIT_W = 5;

   // Defaults
   localparam int DEFAULT_NUM_SLOTS = 256;
   localparam logic [15:0] STRIDE_RESET = 16'd32;

   // Register port geometry
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // Register indexes
   localparam logic [1:0] REG_CPU_BASE    = 2'd0;
   localparam logic [1:0] REG_GPU_BASE    = 2'd1;
   localparam logic [1:0] REG_SLOT_STRIDE = 2'd2;

   // Commands
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FREE_WR,
      ST_ALLOC_WR,
      ST_SCAN
   } seq_state_type;

   // Live configuration
   typedef struct packed {
      logic [63:0] cpu_base;
      logic [63:0] gpu_base;
      logic [15:0] stride;
   } cfg_type;

   // Bitmap memory access: read and write enables
   typedef struct packed {
      logic rd;
      logic wr;
   } mem_op_type;

   // Position of the lowest set bit of a bitmap word
   function automatic logic [WORD_BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
      logic [WORD_BIT_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            pos = WORD_BIT_W'(i);
         end
      end
      return pos;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/descriptor_slot_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// Bitmap slot allocator handing out descriptor slots with CPU and GPU handles.
//
//   channel   ports                               handshake
//   --------  ----------------------------------  ------------------------------
//   request   req_command, req_slot_index         start high while busy low
//   result    rsp_status, rsp_granted_slot,       rsp_strobe, one cycle, no stall
//             rsp_cpu_handle, rsp_gpu_handle
//   config    psel, penable, pwrite, paddr,       APB write on access beat,
//             pwdata, prdata, pready              pready tied high
//
// Error results and full-heap allocates are answered from idle; busy stays low.
// A free is a read and a write-back of its bitmap word.
// An allocate reads and writes back the granted word, then scans up to NUM_WORDS
// words (NUM_SLOTS/32, rounded up) for the lowest free slot through the single
// bitmap memory port; its result comes before the scan. After reset, busy stays
// high while the bitmap is swept word by word to all free; register writes are
// taken throughout. Each result is registered from the step that sets it; the receiver cannot stall.
// ----------------------------------------------------------------------------
module descriptor_slot_allocator #(
   parameter int NUM_SLOTS = dsa_pkg::DEFAULT_NUM_SLOTS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_command,
   input  wire logic [7:0]                     req_slot_index,
   output logic                                rsp_strobe,
   output logic      [1:0]                     rsp_status,
   output logic      [7:0]                     rsp_granted_slot,
   output logic      [63:0]                    rsp_cpu_handle,
   output logic      [63:0]                    rsp_gpu_handle,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [dsa_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [dsa_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [dsa_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);
   import dsa_pkg::*;

   localparam int NUM_WORDS  = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

   cfg_type               cfg;
   mem_op_type            mem_op;
   logic [WORD_IDX_W-1:0] mem_addr;
   logic [WORD_BITS-1:0]  mem_wr_data;
   logic [WORD_BITS-1:0]  mem_rd_data;
   logic                  clr_busy;

   // Register file
   dsa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Free bitmap memory
   dsa_bitmap #(
      .NUM_SLOTS  (NUM_SLOTS),
      .NUM_WORDS  (NUM_WORDS),
      .WORD_IDX_W (WORD_IDX_W)
   ) u_bitmap (
      .clock    (clock),
      .reset    (reset),
      .op       (mem_op),
      .addr     (mem_addr),
      .wr_data  (mem_wr_data),
      .rd_data  (mem_rd_data),
      .clr_busy (clr_busy)
   );

   // Command sequencer
   dsa_seq #(
      .NUM_SLOTS  (NUM_SLOTS),
      .NUM_WORDS  (NUM_WORDS),
      .WORD_IDX_W (WORD_IDX_W)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_slot_index   (req_slot_index),
      .cfg              (cfg),
      .clr_busy         (clr_busy),
      .mem_op           (mem_op),
      .mem_addr         (mem_addr),
      .mem_wr_data      (mem_wr_data),
      .mem_rd_data      (mem_rd_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .rsp_cpu_handle   (rsp_cpu_handle),
      .rsp_gpu_handle   (rsp_gpu_handle)
   );

endmodule
`default_nettype wire

// ===== rtl/dsa_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_csr
// Register file behind the APB-style port: heap bases and slot stride.
// ----------------------------------------------------------------------------
module dsa_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [dsa_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [dsa_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [dsa_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready,
   output dsa_pkg::cfg_type                    cfg
);
   import dsa_pkg::*;

   logic [63:0] cpu_base_ff;
   logic [63:0] gpu_base_ff;
   logic [15:0] stride_ff;
   logic        wr_beat;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_beat = psel && penable && pwrite;
   assign reg_idx = paddr[4:3];

   // Write on the access beat
   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_base_ff <= '0;
         gpu_base_ff <= '0;
         stride_ff   <= STRIDE_RESET;
      end else if (wr_beat) begin
         unique case (reg_idx)
            REG_CPU_BASE:    cpu_base_ff <= pwdata;
            REG_GPU_BASE:    gpu_base_ff <= pwdata;
            REG_SLOT_STRIDE: stride_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_CPU_BASE:    prdata = cpu_base_ff;
         REG_GPU_BASE:    prdata = gpu_base_ff;
         REG_SLOT_STRIDE: prdata = CSR_DATA_W'(stride_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg = '{cpu_base: cpu_base_ff, gpu_base: gpu_base_ff, stride: stride_ff};

endmodule
`default_nettype wire

// ===== rtl/dsa_bitmap.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_bitmap
// Free bitmap in a single-port synchronous memory, 32 slots per word,
// with a clearing pass after reset that marks every slot free.
// ----------------------------------------------------------------------------
module dsa_bitmap #(
   parameter int NUM_SLOTS = dsa_pkg::DEFAULT_NUM_SLOTS,
   parameter int NUM_WORDS = (NUM_SLOTS + dsa_pkg::WORD_BITS - 1) / dsa_pkg::WORD_BITS,
   parameter int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire dsa_pkg::mem_op_type            op,
   input  wire logic [WORD_IDX_W-1:0]          addr,
   input  wire logic [dsa_pkg::WORD_BITS-1:0]  wr_data,
   output logic      [dsa_pkg::WORD_BITS-1:0]  rd_data,
   output logic                                clr_busy
);
   import dsa_pkg::*;

   localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(NUM_WORDS - 1);

   logic [WORD_BITS-1:0]  mem [NUM_WORDS];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  clr_busy_ff;
   logic [WORD_IDX_W-1:0] clr_cnt_ff;
   logic [WORD_BITS-1:0]  init_word;
   logic [31:0]           word_base;

   // Free pattern of one word: only slots below the heap size exist
   always_comb begin
      word_base = 32'({clr_cnt_ff, {WORD_BIT_W{1'b0}}});
      for (int b = 0; b < WORD_BITS; b++) begin
         init_word[b] = (word_base + 32'(b)) < 32'(NUM_SLOTS);
      end
   end

   // Sweep one word per cycle after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == LAST_WORD) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Memory write and registered read
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_cnt_ff] <= init_word;
      end else if (op.wr) begin
         mem[addr] <= wr_data;
      end
      if (op.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule
`default_nettype wire

// ===== rtl/dsa_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_seq
// Command sequencer: read-modify-write of bitmap words, handle arithmetic,
// lowest-free scan after each grant, and the result register.
// ----------------------------------------------------------------------------
module dsa_seq #(
   parameter int NUM_SLOTS = dsa_pkg::DEFAULT_NUM_SLOTS,
   parameter int NUM_WORDS = (NUM_SLOTS + dsa_pkg::WORD_BITS - 1) / dsa_pkg::WORD_BITS,
   parameter int WORD_IDX_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_command,
   input  wire logic [7:0]                    req_slot_index,
   input  wire dsa_pkg::cfg_type              cfg,
   input  wire logic                          clr_busy,
   output dsa_pkg::mem_op_type                mem_op,
   output logic      [WORD_IDX_W-1:0]         mem_addr,
   output logic      [dsa_pkg::WORD_BITS-1:0] mem_wr_data,
   input  wire logic [dsa_pkg::WORD_BITS-1:0] mem_rd_data,
   output logic                               rsp_strobe,
   output logic      [1:0]                    rsp_status,
   output logic      [7:0]                    rsp_granted_slot,
   output logic      [63:0]                   rsp_cpu_handle,
   output logic      [63:0]                   rsp_gpu_handle
);
   import dsa_pkg::*;

   localparam int ADDR_W = WORD_IDX_W + WORD_BIT_W;
   localparam int CNT_W  = WORD_IDX_W + 1;
   localparam logic [WORD_IDX_W-1:0] LAST_WORD  = WORD_IDX_W'(NUM_WORDS - 1);
   localparam logic [CNT_W-1:0]      WORD_COUNT = CNT_W'(NUM_WORDS);

   seq_state_type         state_ff, state_in;
   logic [ADDR_W-1:0]     pend_ff, pend_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [31:0]           prod_ff, prod_in;
   logic [CNT_W-1:0]      issue_ff, issue_in;
   logic                  chk_vld_ff, chk_vld_in;
   logic [WORD_IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic                  strobe_ff, strobe_in;
   logic [1:0]            status_ff, status_in;
   logic [7:0]            slot_ff, slot_in;
   logic [63:0]           cpu_ff, cpu_in;
   logic [63:0]           gpu_ff, gpu_in;
   logic                  idx_in_range;
   logic [ADDR_W-1:0]     req_idx;
   logic [WORD_BITS-1:0]  pend_bit;
   logic [WORD_BITS-1:0]  idx_bit;

   assign idx_in_range = 32'(req_slot_index) < 32'(NUM_SLOTS);
   assign req_idx      = ADDR_W'(req_slot_index);
   assign pend_bit     = WORD_BITS'(1) << pend_ff[WORD_BIT_W-1:0];
   assign idx_bit      = WORD_BITS'(1) << idx_ff[WORD_BIT_W-1:0];

   // State and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_ff     <= '0;
         pend_vld_ff <= 1'b1;
         chk_vld_ff  <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_ff     <= pend_in;
         pend_vld_ff <= pend_vld_in;
         chk_vld_ff  <= chk_vld_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      prod_ff    <= prod_in;
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
      status_ff  <= status_in;
      slot_ff    <= slot_in;
      cpu_ff     <= cpu_in;
      gpu_ff     <= gpu_in;
   end

   // Next state, memory access and result beat
   always_comb begin
      state_in    = state_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      idx_in      = idx_ff;
      prod_in     = prod_ff;
      issue_in    = issue_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      slot_in     = slot_ff;
      cpu_in      = cpu_ff;
      gpu_in      = gpu_ff;
      mem_op      = '0;
      mem_addr    = pend_ff[ADDR_W-1:WORD_BIT_W];
      mem_wr_data = mem_rd_data;
      busy        = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            busy = clr_busy;
            if (start && !clr_busy) begin
               // Preload a zero result for the error and free cases
               status_in = STATUS_OK;
               slot_in   = '0;
               cpu_in    = '0;
               gpu_in    = '0;
               if (req_command == CMD_ALLOC) begin
                  if (!pend_vld_ff) begin
                     status_in = STATUS_FULL;
                     strobe_in = 1'b1;
                  end else begin
                     mem_op.rd = 1'b1;
                     mem_addr  = pend_ff[ADDR_W-1:WORD_BIT_W];
                     prod_in   = 32'(cfg.stride) * 32'(pend_ff);
                     state_in  = ST_ALLOC_WR;
                  end
               end else if (!idx_in_range) begin
                  status_in = STATUS_RANGE;
                  strobe_in = 1'b1;
               end else begin
                  mem_op.rd = 1'b1;
                  mem_addr  = req_idx[ADDR_W-1:WORD_BIT_W];
                  idx_in    = req_idx;
                  state_in  = ST_FREE_WR;
               end
            end
         end

         ST_FREE_WR: begin
            // Set the slot's bit; fill an empty pending slot
            mem_op.wr   = 1'b1;
            mem_addr    = idx_ff[ADDR_W-1:WORD_BIT_W];
            mem_wr_data = mem_rd_data | idx_bit;
            if (!pend_vld_ff) begin
               pend_in     = idx_ff;
               pend_vld_in = 1'b1;
            end
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end

         ST_ALLOC_WR: begin
            // Clear the granted bit and emit its handles
            mem_op.wr   = 1'b1;
            mem_addr    = pend_ff[ADDR_W-1:WORD_BIT_W];
            mem_wr_data = mem_rd_data & ~pend_bit;
            slot_in     = 8'(pend_ff);
            cpu_in      = cfg.cpu_base + 64'(prod_ff);
            gpu_in      = cfg.gpu_base + 64'(prod_ff);
            strobe_in   = 1'b1;
            pend_vld_in = 1'b0;
            issue_in    = '0;
            state_in    = ST_SCAN;
         end

         ST_SCAN: begin
            // Check the word read last cycle, issue the next one
            if (chk_vld_ff && mem_rd_data != '0) begin
               pend_in     = {chk_idx_ff, lowest_set(mem_rd_data)};
               pend_vld_in = 1'b1;
               state_in    = ST_IDLE;
            end else if (chk_vld_ff && chk_idx_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else if (issue_ff < WORD_COUNT) begin
               mem_op.rd  = 1'b1;
               mem_addr   = issue_ff[WORD_IDX_W-1:0];
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[WORD_IDX_W-1:0];
               issue_in   = issue_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_granted_slot = slot_ff;
   assign rsp_cpu_handle   = cpu_ff;
   assign rsp_gpu_handle   = gpu_ff;

endmodule
`default_nettype wire
